@@ rtl/rau_pkg.sv @@
// shared types and constants of the running aggregate unit
package rau_pkg;

	localparam int ACC_W     = 64;
	localparam int KIND_W    = 2;
	localparam int OP_W      = 2;
	localparam int MODE_W    = 3;
	localparam int DIV_ITER_W = $clog2(ACC_W);

	localparam logic [DIV_ITER_W-1:0] DIV_ITER_LAST = DIV_ITER_W'(ACC_W - 1);

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_READ   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [MODE_W-1:0] MODE_MIN   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MAX   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_AVG   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FIRST = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LAST  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SUM   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_COUNT = 3'd6;

	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NUM   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ITEM  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_COUNT = 2'd3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic insert;
		logic clear;
		logic load_direct;
		logic div_start;
		logic div_step;
		logic load_div;
	} rau_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic need_div;
	} rau_stat_t;

endpackage

@@ rtl/rau_ctrl.sv @@
// controller: handshake, read sequencing and divider iteration count
module rau_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rau_pkg::OP_W-1:0]   opcode,
	output logic                       out_valid,
	input  logic                       out_ready,
	input  rau_pkg::rau_stat_t         stat,
	output rau_pkg::rau_cmd_t          cmd
);
	import rau_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]            state_q;
	logic [DIV_ITER_W-1:0] iter_q;
	logic                  out_valid_q;
	logic                  accept;
	logic                  is_read;

	// a read needs the output slot, other opcodes do not
	assign in_ready = (state_q == ST_IDLE) &&
		((opcode != OP_READ) || !out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_read  = accept && (opcode == OP_READ);

	always_comb begin
		cmd             = '0;
		cmd.insert      = accept && (opcode == OP_INSERT);
		cmd.clear       = accept && (opcode == OP_CLEAR);
		cmd.div_start   = is_read && stat.need_div;
		cmd.load_direct = is_read && !stat.need_div;
		cmd.div_step    = (state_q == ST_DIV);
		cmd.load_div    = (state_q == ST_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_direct || cmd.load_div) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.div_start) begin
						state_q <= ST_DIV;
						iter_q  <= '0;
					end
				end
				ST_DIV: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == DIV_ITER_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/rau_dp.sv @@
// datapath: aggregate state, saturating sum, restoring divider, result register
module rau_dp #(
	parameter int VALUE_WIDTH = 48,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rau_pkg::rau_cmd_t             cmd,
	output rau_pkg::rau_stat_t            stat,
	input  logic                          cfg_clear,
	input  logic [rau_pkg::MODE_W-1:0]    mode,
	input  logic                          sample_kind,
	input  logic signed [VALUE_WIDTH-1:0] sample_value,
	output logic [rau_pkg::KIND_W-1:0]    result_kind,
	output logic signed [rau_pkg::ACC_W-1:0] result_value
);
	import rau_pkg::*;

	logic signed [ACC_W-1:0]  acc_q;
	logic [COUNT_WIDTH-1:0]   cnt_q;
	logic                     have_q;
	logic [KIND_W-1:0]        held_kind_q;

	logic signed [ACC_W-1:0]  v;
	logic signed [ACC_W-1:0]  sum;
	logic signed [ACC_W-1:0]  sat_sum;
	logic                     numeric;
	logic [COUNT_WIDTH-1:0]   cnt_inc;

	logic [ACC_W-1:0]         quo_q;
	logic [COUNT_WIDTH-1:0]   rem_q;
	logic                     neg_q;
	logic [COUNT_WIDTH:0]     trial;
	logic [COUNT_WIDTH:0]     diff;
	logic                     fits;

	logic [KIND_W-1:0]        rd_kind;
	logic signed [ACC_W-1:0]  rd_val;
	logic [KIND_W-1:0]        kind_q;
	logic signed [ACC_W-1:0]  val_q;

	assign numeric = sample_kind;
	assign v       = ACC_W'(sample_value);

	// saturating add: overflow only when both signs agree and the sum flips
	assign sum = acc_q + v;
	always_comb begin
		sat_sum = sum;
		if ((acc_q[ACC_W-1] == v[ACC_W-1]) && (sum[ACC_W-1] != acc_q[ACC_W-1])) begin
			sat_sum = acc_q[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
			                         : {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

	assign stat.need_div = (mode == MODE_AVG) && (cnt_q != '0);

	// one quotient bit per step
	assign trial = {rem_q, quo_q[ACC_W-1]};
	assign diff  = trial - {1'b0, cnt_q};
	assign fits  = !diff[COUNT_WIDTH];

	always_comb begin
		rd_kind = KIND_EMPTY;
		rd_val  = '0;
		case (mode)
			MODE_MIN, MODE_MAX, MODE_SUM: begin
				if (have_q) begin
					rd_kind = KIND_NUM;
					rd_val  = acc_q;
				end
			end
			MODE_FIRST, MODE_LAST: begin
				rd_kind = held_kind_q;
				rd_val  = (held_kind_q == KIND_NUM) ? acc_q : '0;
			end
			MODE_COUNT: begin
				rd_kind = KIND_COUNT;
				rd_val  = ACC_W'(cnt_q);
			end
			default: begin
				rd_kind = KIND_EMPTY;
				rd_val  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			have_q      <= 1'b0;
			held_kind_q <= KIND_EMPTY;
		end else if (cfg_clear || cmd.clear) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			have_q      <= 1'b0;
			held_kind_q <= KIND_EMPTY;
		end else if (cmd.insert) begin
			case (mode)
				MODE_MIN: begin
					if (numeric && (!have_q || (v < acc_q))) begin
						acc_q  <= v;
						have_q <= 1'b1;
					end
				end
				MODE_MAX: begin
					if (numeric && (!have_q || (v > acc_q))) begin
						acc_q  <= v;
						have_q <= 1'b1;
					end
				end
				MODE_AVG: begin
					if (numeric) begin
						acc_q <= sat_sum;
						cnt_q <= cnt_inc;
					end
				end
				MODE_FIRST: begin
					if (held_kind_q == KIND_EMPTY) begin
						held_kind_q <= numeric ? KIND_NUM : KIND_ITEM;
						acc_q       <= numeric ? v : '0;
					end
				end
				MODE_LAST: begin
					held_kind_q <= numeric ? KIND_NUM : KIND_ITEM;
					acc_q       <= numeric ? v : '0;
				end
				MODE_SUM: begin
					if (numeric) begin
						acc_q  <= sat_sum;
						have_q <= 1'b1;
					end
				end
				MODE_COUNT: begin
					cnt_q <= cnt_inc;
				end
				default: begin
				end
			endcase
		end
	end

	// divider registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= acc_q[ACC_W-1];
			quo_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[ACC_W-2:0], fits};
			rem_q <= fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_direct) begin
			kind_q <= rd_kind;
			val_q  <= rd_val;
		end else if (cmd.load_div) begin
			kind_q <= KIND_NUM;
			val_q  <= neg_q ? -$signed(quo_q) : $signed(quo_q);
		end
	end

	assign result_kind  = kind_q;
	assign result_value = val_q;

endmodule

@@ rtl/running_aggregate_unit_core.sv @@
// top level of the running aggregate unit: config port, controller and datapath
//
// usage
// - input channel (in_valid / in_ready) carries one beat per command:
//   opcode insert, read or clear, with sample_kind and sample_value
// - output channel (out_valid / out_ready) carries one beat per read:
//   result_kind and result_value
// - insert and clear are taken back to back while no divide runs, and return no beat
// - a read in any mode but average, or in average with a zero count, loads
//   the output register at accept, the beat appears on the next cycle
// - a read in average mode with a nonzero count runs a restoring divider,
//   one quotient bit per cycle over the 64-bit accumulator; the finish state
//   loads the output register and no input is taken meanwhile
// - while the receiver stalls, the result holds in the output register;
//   inserts and clears keep flowing, a further read waits for the slot
// - reset clears the aggregate state, the mode (min) and the output valid
// - writing aggregate_mode over the APB port also clears the aggregate state
module running_aggregate_unit_core #(
	parameter int VALUE_WIDTH = 48,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rau_pkg::OP_W-1:0]      opcode,
	input  logic                          sample_kind,
	input  logic signed [VALUE_WIDTH-1:0] sample_value,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rau_pkg::KIND_W-1:0]    result_kind,
	output logic signed [rau_pkg::ACC_W-1:0] result_value
);
	import rau_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic              mode_wr;
	rau_cmd_t          cmd;
	rau_stat_t         stat;

	// only one register, decoded at byte addresses 0 to 3 (paddr[2] low)
	assign pready  = 1'b1;
	assign mode_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata  = (paddr[2] == 1'b0) ? {{(32-MODE_W){1'b0}}, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MIN;
		end else if (mode_wr) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	// sequencing of accepts, divider iterations and result beats
	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// aggregate state, divider and output register
	rau_dp #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_clear    (mode_wr),
		.mode         (mode_q),
		.sample_kind  (sample_kind),
		.sample_value (sample_value),
		.result_kind  (result_kind),
		.result_value (result_value)
	);

endmodule

@@ tb/sv/tb_running_aggregate_unit_core.sv @@
// testbench of the running aggregate unit: directed and random command streams checked by a predictor
`timescale 1ns / 100ps

module tb_running_aggregate_unit_core;
	import rau_pkg::*;

	localparam int VALUE_W     = 48;
	localparam int COUNT_W     = 32;
	localparam int CYCLE_LIMIT = 2_000_000;
	// room for an average read that is still running the divider
	localparam int DRAIN_CYCLES  = 80;
	// a short pause covers the last inserts and clears
	localparam int SETTLE_CYCLES = 4;

	localparam logic [2:0]        ADDR_MODE   = 3'd0;
	localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
	localparam logic              SAMPLE_ITEM = 1'b0;
	localparam logic              SAMPLE_NUM  = 1'b1;

	localparam logic signed [VALUE_W-1:0] SAMPLE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] SAMPLE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0]   ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0]   ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic signed [ACC_W-1:0] value;
	} readout_t;

	// dut ports, all inputs driven to known values from time zero
	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      psel         = 1'b0;
	logic                      penable      = 1'b0;
	logic                      pwrite       = 1'b0;
	logic [2:0]                paddr        = '0;
	logic [31:0]               pwdata       = '0;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      in_valid     = 1'b0;
	logic                      in_ready;
	logic [OP_W-1:0]           opcode       = '0;
	logic                      sample_kind  = 1'b0;
	logic signed [VALUE_W-1:0] sample_value = '0;
	logic                      out_valid;
	logic                      out_ready    = 1'b0;
	logic [KIND_W-1:0]         result_kind;
	logic signed [ACC_W-1:0]   result_value;

	// predictor state: mirrors the aggregate kept inside the block
	logic [MODE_W-1:0]       agg_mode;
	logic signed [ACC_W-1:0] agg_acc;
	logic [COUNT_W-1:0]      agg_cnt;
	logic                    agg_have;
	logic [KIND_W-1:0]       agg_held;

	// reads accepted whose beat has not come back yet, oldest first
	readout_t pending_readouts[$];

	int fail_count  = 0;
	int cycle_count = 0;
	// chance of an idle burst out of 16, shared by both sides
	int idle_rate   = 0;
	int stall_left  = 0;

	running_aggregate_unit_core #(
		.VALUE_WIDTH(VALUE_W),
		.COUNT_WIDTH(COUNT_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.sample_kind(sample_kind),
		.sample_value(sample_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.result_value(result_value)
	);

	always #5 clk = ~clk;

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: ready drops in bursts of random length while idle_rate is nonzero
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_rate != 0 && int'($urandom_range(0, 15)) < idle_rate) begin
			stall_left = $urandom_range(0, 16);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// every result beat is matched against the oldest outstanding read
	always @(posedge clk) begin
		readout_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_readouts.size() == 0) begin
				$error("result beat with no read outstanding: kind %0d value %0d",
					result_kind, result_value);
				fail_count++;
			end else begin
				want = pending_readouts.pop_front();
				if (result_kind !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
					fail_count++;
				end
				if (result_value !== want.value) begin
					$error("result_value: expected %0d, got %0d", want.value, result_value);
					fail_count++;
				end
			end
		end
	end

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		// a carry out that disagrees with the sign means overflow
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		return s[ACC_W-1:0];
	endfunction

	function automatic void clear_aggregate();
		agg_acc  = '0;
		agg_cnt  = '0;
		agg_have = 1'b0;
		agg_held = KIND_EMPTY;
	endfunction

	// advance the aggregate by one accepted command, queue the readout of a read
	function automatic void aggregate_step(
		input logic [OP_W-1:0]           op,
		input logic                      kind,
		input logic signed [VALUE_W-1:0] raw
	);
		logic signed [ACC_W-1:0] v;
		logic signed [ACC_W-1:0] divisor;
		readout_t r;
		v = {{(ACC_W-VALUE_W){raw[VALUE_W-1]}}, raw};
		case (op)
			OP_INSERT: begin
				case (agg_mode)
					MODE_MIN: begin
						if (kind && (!agg_have || v < agg_acc)) begin
							agg_acc  = v;
							agg_have = 1'b1;
						end
					end
					MODE_MAX: begin
						if (kind && (!agg_have || v > agg_acc)) begin
							agg_acc  = v;
							agg_have = 1'b1;
						end
					end
					MODE_AVG: begin
						if (kind) begin
							agg_acc = sat_add(agg_acc, v);
							if (agg_cnt != '1)
								agg_cnt++;
						end
					end
					MODE_FIRST, MODE_LAST: begin
						if (agg_mode == MODE_LAST || agg_held == KIND_EMPTY) begin
							agg_held = kind ? KIND_NUM : KIND_ITEM;
							agg_acc  = kind ? v : '0;
						end
					end
					MODE_SUM: begin
						if (kind) begin
							agg_acc  = sat_add(agg_acc, v);
							agg_have = 1'b1;
						end
					end
					MODE_COUNT: begin
						if (agg_cnt != '1)
							agg_cnt++;
					end
					default: ;
				endcase
			end
			OP_READ: begin
				r.kind  = KIND_EMPTY;
				r.value = '0;
				case (agg_mode)
					MODE_MIN, MODE_MAX, MODE_SUM: begin
						if (agg_have) begin
							r.kind  = KIND_NUM;
							r.value = agg_acc;
						end
					end
					MODE_AVG: begin
						if (agg_cnt != 0) begin
							// signed division truncates toward zero
							divisor = {{(ACC_W-COUNT_W){1'b0}}, agg_cnt};
							r.kind  = KIND_NUM;
							r.value = agg_acc / divisor;
						end
					end
					MODE_FIRST, MODE_LAST: begin
						r.kind  = agg_held;
						r.value = (agg_held == KIND_NUM) ? agg_acc : '0;
					end
					MODE_COUNT: begin
						r.kind  = KIND_COUNT;
						r.value = {{(ACC_W-COUNT_W){1'b0}}, agg_cnt};
					end
					default: ;
				endcase
				pending_readouts.push_back(r);
			end
			OP_CLEAR: clear_aggregate();
			default: ;
		endcase
	endfunction

	// mix of extremes, full-width noise and small values that keep min and max busy
	function automatic logic signed [VALUE_W-1:0] pick_sample();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return raw[VALUE_W-1:0];
			3: return raw[0] ? '0 : '1;
			default: return {{(VALUE_W-26){raw[25]}}, raw[25:0]};
		endcase
	endfunction

	// one input beat; valid stays up into the next call unless a gap is taken
	task automatic send_command(
		input logic [OP_W-1:0]           op,
		input logic                      kind,
		input logic signed [VALUE_W-1:0] val
	);
		if (idle_rate != 0 && int'($urandom_range(0, 15)) < idle_rate) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		sample_kind  <= kind;
		sample_value <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		aggregate_step(op, kind, val);
	endtask

	// drop valid, let every read come back, then give the last insert time to land
	task automatic settle(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_readouts.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// apb write of the mode register followed by a read back
	task automatic set_mode(input logic [MODE_W-1:0] m);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_MODE;
		pwdata  <= {$urandom_range(0, 1) ? 29'd0 : 29'($urandom), m};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		agg_mode = m;
		clear_aggregate();
		// setup phase of the read back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[MODE_W-1:0] !== m) begin
			$error("aggregate_mode: expected %0d, got %0d", m, prdata[MODE_W-1:0]);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// read straight after reset, then every mode with nothing inserted
	task automatic test_empty_reads();
		logic [MODE_W-1:0] m;
		send_command(OP_READ, SAMPLE_NUM, pick_sample());
		for (int i = 0; i <= int'(MODE_UNUSED); i++) begin
			m = MODE_W'(i);
			settle(SETTLE_CYCLES);
			set_mode(m);
			// the unused mode also has to ignore an insert
			if (m == MODE_UNUSED)
				send_command(OP_INSERT, SAMPLE_NUM, SAMPLE_MAX);
			send_command(OP_READ, SAMPLE_ITEM, pick_sample());
		end
	endtask

	// most positive and most negative samples, non-numeric ones skipped
	task automatic test_extremes();
		settle(SETTLE_CYCLES);
		set_mode(MODE_MIN);
		send_command(OP_INSERT, SAMPLE_NUM, SAMPLE_MAX);
		send_command(OP_INSERT, SAMPLE_NUM, SAMPLE_MIN);
		send_command(OP_INSERT, SAMPLE_ITEM, '0);
		send_command(OP_READ, SAMPLE_NUM, '0);
		settle(SETTLE_CYCLES);
		set_mode(MODE_MAX);
		send_command(OP_INSERT, SAMPLE_NUM, SAMPLE_MIN);
		send_command(OP_INSERT, SAMPLE_ITEM, SAMPLE_MAX);
		send_command(OP_READ, SAMPLE_NUM, '1);
	endtask

	// first and last capture non-numeric items, clear empties the capture
	task automatic test_capture();
		settle(SETTLE_CYCLES);
		set_mode(MODE_FIRST);
		send_command(OP_INSERT, SAMPLE_ITEM, SAMPLE_MAX);
		send_command(OP_INSERT, SAMPLE_NUM, 48'sd5);
		send_command(OP_READ, SAMPLE_NUM, '0);
		send_command(OP_CLEAR, SAMPLE_NUM, '1);
		send_command(OP_READ, SAMPLE_NUM, '0);
		settle(SETTLE_CYCLES);
		set_mode(MODE_LAST);
		send_command(OP_INSERT, SAMPLE_NUM, SAMPLE_MIN);
		send_command(OP_INSERT, SAMPLE_ITEM, 48'sd9);
		send_command(OP_READ, SAMPLE_NUM, '0);
	endtask

	// negative average truncates toward zero, count ignores the unused opcode
	task automatic test_average_and_unused();
		settle(SETTLE_CYCLES);
		set_mode(MODE_AVG);
		send_command(OP_INSERT, SAMPLE_NUM, -48'sd7);
		send_command(OP_INSERT, SAMPLE_ITEM, SAMPLE_MAX);
		send_command(OP_INSERT, SAMPLE_NUM, 48'sd2);
		send_command(OP_READ, SAMPLE_NUM, '0);
		settle(SETTLE_CYCLES);
		set_mode(MODE_COUNT);
		send_command(OP_INSERT, SAMPLE_ITEM, '0);
		send_command(OP_UNUSED, SAMPLE_NUM, SAMPLE_MAX);
		send_command(OP_READ, SAMPLE_NUM, '0);
	endtask

	// one mode, a run of random commands, mostly insert bursts with reads between
	task automatic random_phase(input logic [MODE_W-1:0] m, input int items);
		int r;
		logic [OP_W-1:0] op;
		settle(SETTLE_CYCLES);
		set_mode(m);
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				op = OP_INSERT;
			else if (r < 88)
				op = OP_READ;
			else if (r < 96)
				op = OP_CLEAR;
			else
				op = OP_UNUSED;
			send_command(op, $urandom_range(0, 6) != 0, pick_sample());
		end
	endtask

	// every mode in turn with varying idle pressure, a few extra phases on top
	task automatic test_random_modes();
		int start;
		int m;
		start = $urandom_range(0, 6);
		for (int p = 0; p < 14; p++) begin
			case ($urandom_range(0, 2))
				0: idle_rate = 0;
				1: idle_rate = 3;
				default: idle_rate = 8;
			endcase
			if (p < 7)
				m = (start + p) % 7;
			else if (p == 7)
				m = MODE_UNUSED;
			else
				m = $urandom_range(0, 6);
			random_phase(MODE_W'(m), (m == MODE_UNUSED) ? 30 : 72);
		end
	endtask

	// closing stretch at full rate on both sides
	task automatic test_steady_stream();
		idle_rate = 0;
		random_phase(MODE_W'($urandom_range(0, 6)), 60);
	endtask

	initial begin
		agg_mode = MODE_MIN;
		clear_aggregate();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_rate = 4;
		test_empty_reads();
		test_extremes();
		test_capture();
		test_average_and_unused();
		test_random_modes();
		test_steady_stream();
		// wait out the last reads and any divider still running
		settle(DRAIN_CYCLES);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_dp.sv
rtl/running_aggregate_unit_core.sv
tb/sv/tb_running_aggregate_unit_core.sv
